[sv/rectangle_page_join_unit_assert.svh]
// Assertion macros for the rectangle page join unit
`ifndef RECTANGLE_PAGE_JOIN_UNIT_ASSERT_SVH
`define RECTANGLE_PAGE_JOIN_UNIT_ASSERT_SVH

// same-cycle implication, muted while reset is held
`define RPJ_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, muted while reset is held
`define RPJ_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error(msg);

`endif

[sv/rpj_pkg.sv]
// Shared types and constants of the rectangle page join unit
`timescale 1ns / 1ps
`default_nettype none

package rpj_pkg;

    localparam int ID_WIDTH  = 31;
    localparam int CMD_WIDTH = 2;

    localparam logic [CMD_WIDTH-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_PROBE  = 2'd2;

    typedef enum logic [1:0] {
        JOB_CLEAR,
        JOB_APPEND,
        JOB_PROBE,
        JOB_NOP
    } t_job_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FLUSH
    } t_back_state;

    typedef struct packed {
        logic [ID_WIDTH-1:0] probe_id;
        logic [ID_WIDTH-1:0] stored_id;
        logic                hit;
        logic                page_full;
        logic                last;
    } t_result;

endpackage

`default_nettype wire

[sv/rpj_in_if.sv]
// Input item channel: command and rectangle
`timescale 1ns / 1ps
`default_nettype none

interface rpj_in_if #(
    parameter int COORD_WIDTH = 32
) ();
    logic                                   valid;
    logic                                   ready;
    logic [rpj_pkg::CMD_WIDTH-1:0]          command;
    logic [rpj_pkg::ID_WIDTH-1:0]           obj_id;
    logic signed [COORD_WIDTH-1:0]          left;
    logic signed [COORD_WIDTH-1:0]          right;
    logic signed [COORD_WIDTH-1:0]          top;
    logic signed [COORD_WIDTH-1:0]          bottom;

    modport source (output valid, command, obj_id, left, right, top, bottom, input ready);
    modport sink   (input valid, command, obj_id, left, right, top, bottom, output ready);
endinterface

`default_nettype wire

[sv/rpj_out_if.sv]
// Result channel: pair of ids and status flags
`timescale 1ns / 1ps
`default_nettype none

interface rpj_out_if ();
    logic                          valid;
    logic                          ready;
    logic [rpj_pkg::ID_WIDTH-1:0]  probe_id;
    logic [rpj_pkg::ID_WIDTH-1:0]  stored_id;
    logic                          hit;
    logic                          page_full;
    logic                          last;

    modport source (output valid, probe_id, stored_id, hit, page_full, last, input ready);
    modport sink   (input valid, probe_id, stored_id, hit, page_full, last, output ready);
endinterface

`default_nettype wire

[sv/rpj_cfg_if.sv]
// Configuration write channel for the touch rule register
`timescale 1ns / 1ps
`default_nettype none

interface rpj_cfg_if ();
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[sv/rectangle_page_join_unit.sv]
// Top level of the rectangle page join unit
//
//   port    dir  role      payload
//   i_in    in   sink      command, obj_id, left, right, top, bottom
//   o_out   out  source    probe_id, stored_id, hit, page_full, last
//   i_cfg   in   sink      data = touch_counts (1 bit)
//
// Clear, append and unused commands each give one result.
// A probe scans the stored entries in order: the page store has one read port, so one
// entry is compared per cycle while the scan is not held by a stalled o_out.
// i_rst_n is synchronous: empties the queue and store count, sets touch_counts to 1;
// the page store itself is not cleared. A stalled o_out holds the scan only when a
// second hit is waiting; the front queue takes items until its two entries are full.
`timescale 1ns / 1ps
`default_nettype none

`include "rectangle_page_join_unit_assert.svh"

module rectangle_page_join_unit #(
    parameter int PAGE_DEPTH  = 64,
    parameter int COORD_WIDTH = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    rpj_in_if.sink     i_in,
    rpj_out_if.source  o_out,
    rpj_cfg_if.sink    i_cfg
);
    import rpj_pkg::*;

    // config register: 1 = closed intervals (touching edges overlap)
    logic r_touch_counts, n_touch_counts;

    // job channel between front queue and back end
    logic                     job_valid;
    logic                     job_ready;
    t_job_kind                job_kind;
    logic [ID_WIDTH-1:0]      job_id;
    logic [4*COORD_WIDTH-1:0] job_rect;

    logic    res_valid;
    t_result res;

    // terms watched by the assertions
    logic in_xfer;
    logic res_full;
    logic res_miss;

    assign i_cfg.ready    = 1'b1;
    assign n_touch_counts = (i_cfg.valid && i_cfg.ready) ? i_cfg.data : r_touch_counts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_counts <= 1'b1;
        end else begin
            r_touch_counts <= n_touch_counts;
        end
    end

    // front: decode command, two-entry queue
    rpj_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job_kind  (job_kind),
        .o_job_id    (job_id),
        .o_job_rect  (job_rect)
    );

    // back: page store, scan, result register
    rpj_back #(
        .PAGE_DEPTH  (PAGE_DEPTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_touch_counts (r_touch_counts),
        .i_job_valid    (job_valid),
        .o_job_ready    (job_ready),
        .i_job_kind     (job_kind),
        .i_job_id       (job_id),
        .i_job_rect     (job_rect),
        .o_res_valid    (res_valid),
        .i_res_ready    (o_out.ready),
        .o_res          (res)
    );

    assign o_out.valid     = res_valid;
    assign o_out.probe_id  = res.probe_id;
    assign o_out.stored_id = res.stored_id;
    assign o_out.hit       = res.hit;
    assign o_out.page_full = res.page_full;
    assign o_out.last      = res.last;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign res_full = res_valid && res.page_full;
    assign res_miss = res_valid && !res.hit;

    // a transfer into the front always leaves a job queued for the back end
    `RPJ_ASSERT_NEXT(a_job_after_accept, i_clk, i_rst_n, in_xfer, job_valid, "item lost")

    // a dropped append never carries a pair and always closes its item
    `RPJ_ASSERT_NOW(a_full_last, i_clk, i_rst_n, res_full, res.last && !res.hit, "bad full")

    // results without a pair carry no stored id
    `RPJ_ASSERT_NOW(a_miss_no_sid, i_clk, i_rst_n, res_miss, res.stored_id == '0, "stray sid")

endmodule

`default_nettype wire

[sv/rpj_front.sv]
// Front end: classifies input items and queues them for the back end
`timescale 1ns / 1ps
`default_nettype none

module rpj_front #(
    parameter int COORD_WIDTH = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    rpj_in_if.sink                         i_in,
    output logic                           o_job_valid,
    input  wire                            i_job_ready,
    output rpj_pkg::t_job_kind             o_job_kind,
    output logic [rpj_pkg::ID_WIDTH-1:0]   o_job_id,
    output logic [4*COORD_WIDTH-1:0]       o_job_rect
);
    import rpj_pkg::*;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QFILL_W     = 2;

    t_job_kind                r_kind [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0]      r_id   [QUEUE_DEPTH];
    logic [4*COORD_WIDTH-1:0] r_rect [QUEUE_DEPTH];
    logic [QPTR_W-1:0]        r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]        r_rd_ptr, n_rd_ptr;
    logic [QFILL_W-1:0]       r_fill, n_fill;

    t_job_kind kind;
    logic      push;
    logic      pop;

    // map the command code onto a job kind
    always_comb begin
        unique case (i_in.command)
            CMD_CLEAR:  kind = JOB_CLEAR;
            CMD_APPEND: kind = JOB_APPEND;
            CMD_PROBE:  kind = JOB_PROBE;
            default:    kind = JOB_NOP;
        endcase
    end

    assign i_in.ready  = (r_fill != QFILL_W'(QUEUE_DEPTH));
    assign push        = i_in.valid && i_in.ready;
    assign o_job_valid = (r_fill != '0);
    assign pop         = o_job_valid && i_job_ready;

    assign o_job_kind = r_kind[r_rd_ptr];
    assign o_job_id   = r_id[r_rd_ptr];
    assign o_job_rect = r_rect[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_fill   = r_fill + QFILL_W'(push) - QFILL_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_kind[r_wr_ptr] <= kind;
            r_id[r_wr_ptr]   <= i_in.obj_id;
            r_rect[r_wr_ptr] <= {i_in.left, i_in.right, i_in.top, i_in.bottom};
        end
    end

endmodule

`default_nettype wire

[sv/rpj_back.sv]
// Back end: page store, probe scan and result register
`timescale 1ns / 1ps
`default_nettype none

module rpj_back #(
    parameter int PAGE_DEPTH  = 64,
    parameter int COORD_WIDTH = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_touch_counts,
    input  wire                            i_job_valid,
    output logic                           o_job_ready,
    input  rpj_pkg::t_job_kind             i_job_kind,
    input  wire [rpj_pkg::ID_WIDTH-1:0]    i_job_id,
    input  wire [4*COORD_WIDTH-1:0]        i_job_rect,
    output logic                           o_res_valid,
    input  wire                            i_res_ready,
    output rpj_pkg::t_result               o_res
);
    import rpj_pkg::*;

    localparam int ADDR_W = (PAGE_DEPTH > 1) ? $clog2(PAGE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(PAGE_DEPTH + 1);
    localparam int RECT_W = 4 * COORD_WIDTH;
    localparam int WORD_W = ID_WIDTH + RECT_W;

    // page store: {id, left, right, top, bottom}
    logic [WORD_W-1:0] mem [PAGE_DEPTH];

    t_back_state         r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_issue, n_issue;
    logic                r_b_valid, n_b_valid;
    logic [WORD_W-1:0]   r_rd_word;
    logic [ID_WIDTH-1:0] r_probe_id, n_probe_id;
    logic [RECT_W-1:0]   r_probe_rect, n_probe_rect;
    logic                r_pend_valid, n_pend_valid;
    logic [ID_WIDTH-1:0] r_pend_sid, n_pend_sid;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    logic job_pop;
    logic mem_we;
    logic rd_en;
    logic out_free;
    logic b_hit;
    logic b_stall;

    logic signed [COORD_WIDTH-1:0] p_l, p_r, p_t, p_b;
    logic signed [COORD_WIDTH-1:0] s_l, s_r, s_t, s_b;
    logic [ID_WIDTH-1:0]           s_id;

    // a < b separates; with touching edges not counted, a == b separates too
    function automatic logic gap(input logic signed [COORD_WIDTH-1:0] a,
                                 input logic signed [COORD_WIDTH-1:0] b,
                                 input logic touch);
        return (a < b) || (!touch && (a == b));
    endfunction

    assign {p_l, p_r, p_t, p_b} = r_probe_rect;
    assign {s_id, s_l, s_r, s_t, s_b} = r_rd_word;

    assign b_hit = !(gap(p_r, s_l, i_touch_counts) || gap(s_r, p_l, i_touch_counts) ||
                     gap(s_t, p_b, i_touch_counts) || gap(p_t, s_b, i_touch_counts));

    assign out_free    = !r_out_valid || i_res_ready;
    assign b_stall     = r_b_valid && b_hit && r_pend_valid && !out_free;
    assign o_job_ready = job_pop;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_issue      = r_issue;
        n_b_valid    = r_b_valid;
        n_probe_id   = r_probe_id;
        n_probe_rect = r_probe_rect;
        n_pend_valid = r_pend_valid;
        n_pend_sid   = r_pend_sid;
        n_out_valid  = r_out_valid && !i_res_ready;
        n_out        = r_out;
        job_pop      = 1'b0;
        mem_we       = 1'b0;
        rd_en        = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    unique case (i_job_kind)
                        JOB_PROBE: begin
                            job_pop      = 1'b1;
                            n_probe_id   = i_job_id;
                            n_probe_rect = i_job_rect;
                            n_issue      = '0;
                            n_b_valid    = 1'b0;
                            n_pend_valid = 1'b0;
                            n_state      = (r_count == '0) ? BK_FLUSH : BK_SCAN;
                        end
                        JOB_APPEND: begin
                            if (out_free) begin
                                job_pop     = 1'b1;
                                n_out_valid = 1'b1;
                                n_out       = '0;
                                n_out.last  = 1'b1;
                                if (r_count < CNT_W'(PAGE_DEPTH)) begin
                                    mem_we  = 1'b1;
                                    n_count = r_count + CNT_W'(1);
                                end else begin
                                    n_out.page_full = 1'b1;
                                end
                            end
                        end
                        JOB_CLEAR: begin
                            if (out_free) begin
                                job_pop     = 1'b1;
                                n_count     = '0;
                                n_out_valid = 1'b1;
                                n_out       = '0;
                                n_out.last  = 1'b1;
                            end
                        end
                        default: begin
                            if (out_free) begin
                                job_pop     = 1'b1;
                                n_out_valid = 1'b1;
                                n_out       = '0;
                                n_out.last  = 1'b1;
                            end
                        end
                    endcase
                end
            end
            BK_SCAN: begin
                if (!b_stall) begin
                    // a new hit pushes the held one out, not yet last
                    if (r_b_valid && b_hit) begin
                        if (r_pend_valid) begin
                            n_out_valid     = 1'b1;
                            n_out           = '0;
                            n_out.probe_id  = r_probe_id;
                            n_out.stored_id = r_pend_sid;
                            n_out.hit       = 1'b1;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_sid   = s_id;
                    end
                    if (r_issue < r_count) begin
                        rd_en     = 1'b1;
                        n_issue   = r_issue + CNT_W'(1);
                        n_b_valid = 1'b1;
                    end else begin
                        n_b_valid = 1'b0;
                    end
                    if ((r_issue == r_count) && !r_b_valid) begin
                        n_state = BK_FLUSH;
                    end
                end
            end
            BK_FLUSH: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out          = '0;
                    n_out.probe_id = r_probe_id;
                    n_out.last     = 1'b1;
                    if (r_pend_valid) begin
                        n_out.stored_id = r_pend_sid;
                        n_out.hit       = 1'b1;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_count      <= '0;
            r_issue      <= '0;
            r_b_valid    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_issue      <= n_issue;
            r_b_valid    <= n_b_valid;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe_id   <= n_probe_id;
        r_probe_rect <= n_probe_rect;
        r_pend_sid   <= n_pend_sid;
        r_out        <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[ADDR_W-1:0]] <= {i_job_id, i_job_rect};
        end
        if (rd_en) begin
            r_rd_word <= mem[r_issue[ADDR_W-1:0]];
        end
    end

endmodule

`default_nettype wire

[bench/rectangle_page_join_unit_checker.sv]
// Scoreboard for the rectangle page join unit: predicts each result and checks it
`timescale 1ns / 1ps

module rectangle_page_join_unit_checker #(
    parameter int PAGE_DEPTH  = 64,
    parameter int COORD_WIDTH = 32
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_end_check,
    rpj_in_if    i_in,
    rpj_out_if   i_out,
    rpj_cfg_if   i_cfg,
    output int   o_fail_count
);
    import rpj_pkg::*;

    localparam int PRINT_CAP = 40;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    // shadow copy of the stored page
    logic [ID_WIDTH-1:0] page_id     [PAGE_DEPTH];
    coord_t              page_left   [PAGE_DEPTH];
    coord_t              page_right  [PAGE_DEPTH];
    coord_t              page_top    [PAGE_DEPTH];
    coord_t              page_bottom [PAGE_DEPTH];
    int                  page_count;
    logic                touch_rule;

    t_result             expected_pairs[$];
    t_result             want;
    int                  result_idx;
    bit                  end_done;

    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_CAP)
            $display("ERROR @%0t: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [ID_WIDTH-1:0] got,
                               input logic [ID_WIDTH-1:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      result_idx, name, got, exp_val));
    endtask

    // Probe rectangle against stored entry k. Touching edges are a hit only
    // under the closed-interval rule.
    function automatic bit rects_meet(input coord_t l, r, t, b, input int k,
                                      input logic touch);
        if (touch)
            return !(r < page_left[k] || page_right[k] < l ||
                     page_top[k] < b || t < page_bottom[k]);
        return !(r <= page_left[k] || page_right[k] <= l ||
                 page_top[k] <= b || t <= page_bottom[k]);
    endfunction

    task automatic join_item(input logic [CMD_WIDTH-1:0] cmd, input logic [ID_WIDTH-1:0] id,
                             input coord_t l, r, t, b);
        t_result res;
        int      hits;
        int      seen;
        int      k;
        res      = '0;
        res.last = 1'b1;
        hits     = 0;
        seen     = 0;
        case (cmd)
            CMD_CLEAR: begin
                page_count = 0;
            end
            CMD_APPEND: begin
                if (page_count >= PAGE_DEPTH) begin
                    res.page_full = 1'b1;
                end else begin
                    page_id[page_count]     = id;
                    page_left[page_count]   = l;
                    page_right[page_count]  = r;
                    page_top[page_count]    = t;
                    page_bottom[page_count] = b;
                    page_count++;
                end
            end
            CMD_PROBE: begin
                res.probe_id = id;
                for (k = 0; k < page_count; k++)
                    if (rects_meet(l, r, t, b, k, touch_rule))
                        hits++;
                for (k = 0; k < page_count; k++) begin
                    if (rects_meet(l, r, t, b, k, touch_rule)) begin
                        seen++;
                        res.stored_id = page_id[k];
                        res.hit       = 1'b1;
                        res.last      = (seen == hits);
                        expected_pairs.insert(expected_pairs.size(), res);
                    end
                end
            end
            default: begin
            end
        endcase
        // everything but a probe with hits gives one closing result
        if (!(cmd == CMD_PROBE && hits > 0))
            expected_pairs.insert(expected_pairs.size(), res);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            page_count   = 0;
            touch_rule   = 1'b1;
            result_idx   = 0;
            end_done     = 1'b0;
            o_fail_count = 0;
            expected_pairs.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                touch_rule = i_cfg.data;
            if (i_in.valid && i_in.ready)
                join_item(i_in.command, i_in.obj_id, i_in.left, i_in.right,
                          i_in.top, i_in.bottom);
            if (i_out.valid && i_out.ready) begin
                if (expected_pairs.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_idx));
                end else begin
                    want = expected_pairs.pop_front();
                    check_field("probe_id", i_out.probe_id, want.probe_id);
                    check_field("stored_id", i_out.stored_id, want.stored_id);
                    check_field("hit", ID_WIDTH'(i_out.hit), ID_WIDTH'(want.hit));
                    check_field("page_full", ID_WIDTH'(i_out.page_full),
                                ID_WIDTH'(want.page_full));
                    check_field("last", ID_WIDTH'(i_out.last), ID_WIDTH'(want.last));
                end
                result_idx++;
            end
            if (i_end_check && !end_done) begin
                end_done = 1'b1;
                while (expected_pairs.size() != 0) begin
                    want = expected_pairs.pop_front();
                    report_mismatch($sformatf(
                        "expected result never came: probe 0x%0h stored 0x%0h",
                        want.probe_id, want.stored_id));
                end
            end
        end
    end

endmodule

[bench/rectangle_page_join_unit_tb.sv]
// Testbench top for the rectangle page join unit: stimulus, flow control and verdict
`timescale 1ns / 1ps

module rectangle_page_join_unit_tb;
    import rpj_pkg::*;

    localparam int PAGE_DEPTH   = 64;
    localparam int COORD_WIDTH  = 32;
    localparam int RANDOM_ITEMS = 64;
    // no-transfer limit: long sender gap + full-page probe + long result stall, several times
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = PAGE_DEPTH + 8;

    // command code that the block must ignore
    localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam coord_t              C_MIN  = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam coord_t              C_MAX  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t              ONE    = coord_t'(32'sh0001_0000);   // 1.0 in Q16.16
    localparam logic [ID_WIDTH-1:0] ID_MAX = '1;

    logic   clk;
    logic   rst_n;
    logic   quiet;          // no idling on either side while set
    logic   end_check;
    int     fail_count;
    int     items_sent;     // accepted input transfers
    int     items_done;     // result transfers that closed an item
    int     idle_cycles;
    int     stall_left;
    coord_t grid_x;
    coord_t grid_y;
    coord_t grid_step;

    rpj_in_if #(.COORD_WIDTH(COORD_WIDTH)) in_ch ();
    rpj_out_if                             out_ch ();
    rpj_cfg_if                             cfg_ch ();

    rectangle_page_join_unit #(
        .PAGE_DEPTH  (PAGE_DEPTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    rectangle_page_join_unit_checker #(
        .PAGE_DEPTH  (PAGE_DEPTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_end_check  (end_check),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_length();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side back-pressure.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= idle_length() - 1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Every item ends with exactly one result flagged last, so counting those
    // tells when the block has gone idle.
    always @(posedge clk) begin
        if (!rst_n) begin
            items_done <= 0;
        end else if (out_ch.valid && out_ch.ready && out_ch.last) begin
            items_done <= items_done + 1;
        end
    end

    // Watchdog: too long without any transfer on any channel ends the run.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one item and hold it until the transfer. Called at a rising edge,
    // returns at the edge of the transfer.
    task automatic send_item(input logic [CMD_WIDTH-1:0] cmd, input logic [ID_WIDTH-1:0] id,
                             input coord_t l, r, t, b);
        if (!quiet && $urandom_range(0, 2) == 0) begin
            in_ch.valid <= 1'b0;
            repeat (idle_length()) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.obj_id  <= id;
        in_ch.left    <= l;
        in_ch.right   <= r;
        in_ch.top     <= t;
        in_ch.bottom  <= b;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    // Rectangle on a coarse grid so that overlaps and shared edges are common.
    task automatic send_grid_rect(input logic [CMD_WIDTH-1:0] cmd);
        coord_t l, r, t, b;
        int     x0, y0;
        x0 = $urandom_range(0, 7);
        y0 = $urandom_range(0, 7);
        l  = grid_x + coord_t'(x0) * grid_step;
        r  = l + coord_t'($urandom_range(0, 3)) * grid_step;
        b  = grid_y + coord_t'(y0) * grid_step;
        t  = b + coord_t'($urandom_range(0, 3)) * grid_step;
        // one-LSB nudge: turns a touch into a gap or a sliver of overlap
        if ($urandom_range(0, 7) == 0)
            r = r + coord_t'($urandom_range(0, 2)) - coord_t'(1);
        if ($urandom_range(0, 7) == 0)
            b = b + coord_t'($urandom_range(0, 2)) - coord_t'(1);
        // occasional inverted rectangle
        if ($urandom_range(0, 15) == 0)
            {l, r} = {r, l};
        send_item(cmd, ID_WIDTH'($urandom), l, r, t, b);
    endtask

    task automatic send_noise();
        send_item(CMD_WIDTH'($urandom_range(0, 3)), ID_WIDTH'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    endtask

    task automatic pick_grid();
        grid_x = coord_t'($urandom);
        grid_y = coord_t'($urandom);
        case ($urandom_range(0, 3))
            0:       grid_step = coord_t'(1);
            1:       grid_step = coord_t'($urandom_range(2, 1000));
            default: grid_step = ONE;
        endcase
    endtask

    // Drop valid and wait until every item has closed.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (items_done != items_sent) @(posedge clk);
    endtask

    task automatic write_touch_rule(input logic rule);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= rule;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        int rule;
        int fill_end;
        int n_append;

        in_ch.valid   = 1'b0;
        in_ch.command = CMD_CLEAR;
        in_ch.obj_id  = '0;
        in_ch.left    = '0;
        in_ch.right   = '0;
        in_ch.top     = '0;
        in_ch.bottom  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = 1'b0;
        rst_n         = 1'b0;
        quiet         = 1'b0;
        end_check     = 1'b0;
        items_sent    = 0;
        grid_x        = '0;
        grid_y        = '0;
        grid_step     = ONE;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part ---
        // probe on an empty page: single no-hit result
        send_item(CMD_PROBE, ID_MAX, C_MIN, C_MAX, C_MAX, C_MIN);
        // unused command code is ignored
        send_item(CMD_UNUSED, ID_MAX, C_MAX, C_MIN, C_MIN, C_MAX);
        send_item(CMD_CLEAR, '0, '0, '0, '0, '0);
        // whole plane, unit square, its right neighbor, and an inverted one
        send_item(CMD_APPEND, '0, C_MIN, C_MAX, C_MAX, C_MIN);
        send_item(CMD_APPEND, ID_MAX, '0, ONE, ONE, '0);
        send_item(CMD_APPEND, 31'd5, ONE, 2 * ONE, ONE, '0);
        send_item(CMD_APPEND, 31'd6, 3 * ONE, 2 * ONE, 4 * ONE, 5 * ONE);
        // same probes under both rules: edge touch, corner touch, far-corner point,
        // and an inverted probe
        for (rule = 1; rule >= 0; rule--) begin
            wait_idle();
            write_touch_rule(rule[0]);
            send_item(CMD_PROBE, 31'd100, '0, ONE, ONE, '0);
            send_item(CMD_PROBE, 31'd101, 2 * ONE, 3 * ONE, 2 * ONE, ONE);
            send_item(CMD_PROBE, 31'd102, C_MAX, C_MAX, C_MIN, C_MIN);
            send_item(CMD_PROBE, 31'd103, 3 * ONE, 2 * ONE, 5 * ONE, 4 * ONE);
        end

        // --- full page: overflowing appends, then probes that hit up to every entry ---
        wait_idle();
        write_touch_rule(1'b1);
        grid_x    = '0;
        grid_y    = '0;
        grid_step = ONE;
        send_item(CMD_CLEAR, ID_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        repeat (PAGE_DEPTH + 2) send_grid_rect(CMD_APPEND);
        repeat (3) send_grid_rect(CMD_PROBE);
        send_item(CMD_PROBE, 31'd1, C_MIN, C_MAX, C_MAX, C_MIN);

        // --- random part: mostly clear / append / probe sequences, some noise ---
        fill_end = items_sent;
        while (items_sent < fill_end + RANDOM_ITEMS) begin
            wait_idle();
            write_touch_rule(1'($urandom_range(0, 1)));
            quiet <= ($urandom_range(0, 4) == 0);
            pick_grid();
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 4)) send_noise();
            end else begin
                send_item(CMD_CLEAR, ID_WIDTH'($urandom), coord_t'($urandom),
                          coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
                n_append = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24)
                                                       : $urandom_range(1, 10);
                repeat (n_append) begin
                    send_grid_rect(CMD_APPEND);
                    if ($urandom_range(0, 15) == 0)
                        send_noise();
                end
                repeat ($urandom_range(2, 6)) send_grid_rect(CMD_PROBE);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        end_check <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[rectangle_page_join_unit.f]
+incdir+sv
sv/rpj_pkg.sv
sv/rpj_in_if.sv
sv/rpj_out_if.sv
sv/rpj_cfg_if.sv
sv/rpj_front.sv
sv/rpj_back.sv
sv/rectangle_page_join_unit.sv
bench/rectangle_page_join_unit_checker.sv
bench/rectangle_page_join_unit_tb.sv
